[src/uri_percent_escape_defines.svh]
// ----------------------------------------------------------------------------
// uri_percent_escape_defines
// Assertion macros for the percent-escape block.
// ----------------------------------------------------------------------------
`ifndef URI_PERCENT_ESCAPE_DEFINES_SVH
`define URI_PERCENT_ESCAPE_DEFINES_SVH

// Property that holds at every clock edge out of reset.
`define UPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define UPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/upe_pkg.sv]
// ----------------------------------------------------------------------------
// upe_pkg
// Shared types, constants and escape-set tables for the percent-escape block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package upe_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned TOTAL_W     = 18;
  localparam int unsigned SET_W       = 3;
  localparam int unsigned CFG_DATA_W  = 3;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [0:0] {
    CFG_ESCAPE_SET = 1'b0,
    CFG_COUNT_ONLY = 1'b1
  } cfg_idx_e;

  typedef enum logic [SET_W-1:0] {
    SET_URI       = 3'd0,
    SET_ARGS      = 3'd1,
    SET_COMPONENT = 3'd2,
    SET_URL       = 3'd3,
    SET_MAIL      = 3'd4
  } set_sel_e;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       esc;
    logic       count_only;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  localparam logic [255:0] SET_URI_BITS = {
    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
    32'h80000000, 32'h00000000, 32'h80000029, 32'hffffffff
  };
  localparam logic [255:0] SET_ARGS_BITS = {
    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
    32'h80000000, 32'h00000000, 32'h88000869, 32'hffffffff
  };
  localparam logic [255:0] SET_COMPONENT_BITS = {
    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
    32'hb8000001, 32'h78000001, 32'hfc009fff, 32'hffffffff
  };
  localparam logic [255:0] SET_URL_BITS = {
    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
    32'h80000000, 32'h00000000, 32'h000000ad, 32'hffffffff
  };
  localparam logic [255:0] SET_MAIL_BITS = {
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000021, 32'hffffffff
  };

  function automatic logic needs_escape(logic [SET_W-1:0] sel, logic [7:0] b);
    logic res;
    unique case (sel)
      SET_URI:       res = SET_URI_BITS[b];
      SET_ARGS:      res = SET_ARGS_BITS[b];
      SET_COMPONENT: res = SET_COMPONENT_BITS[b];
      SET_URL:       res = SET_URL_BITS[b];
      SET_MAIL:      res = SET_MAIL_BITS[b];
      default:       res = 1'b0;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    logic [7:0] res;
    if (n < 4'd10) begin
      res = 8'h30 + {4'd0, n};
    end else begin
      res = 8'h57 + {4'd0, n};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[src/upe_front.sv]
// ----------------------------------------------------------------------------
// upe_front
// Holds the configuration registers and classifies each source byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upe_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [0:0]                       cfg_index_i,
  input  wire logic [upe_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic [7:0]                       src_byte_i,
  input  wire logic                             src_last_i,
  output upe_pkg::cmd_t                         cmd_o
);
  import upe_pkg::*;

  logic [SET_W-1:0] escape_set_q, escape_set_d;
  logic             count_only_q, count_only_d;

  always_comb begin
    escape_set_d = escape_set_q;
    count_only_d = count_only_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ESCAPE_SET: escape_set_d = cfg_data_i[SET_W-1:0];
        CFG_COUNT_ONLY: count_only_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_set_q <= '0;
      count_only_q <= 1'b0;
    end else begin
      escape_set_q <= escape_set_d;
      count_only_q <= count_only_d;
    end
  end

  assign cmd_o.src_byte   = src_byte_i;
  assign cmd_o.esc        = needs_escape(escape_set_q, src_byte_i);
  assign cmd_o.count_only = count_only_q;
  assign cmd_o.last       = src_last_i;

endmodule

`default_nettype wire

[src/upe_queue.sv]
// ----------------------------------------------------------------------------
// upe_queue
// Small command queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upe_queue #(
  parameter int unsigned DEPTH = upe_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  upe_pkg::cmd_t          push_data_i,
  input  wire logic              pop_i,
  output upe_pkg::cmd_t          head_o,
  output upe_pkg::queue_status_t status_o
);
  import upe_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[src/upe_back.sv]
// ----------------------------------------------------------------------------
// upe_back
// Emits result bytes for queued commands and keeps the running total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upe_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  upe_pkg::cmd_t                      head_i,
  input  upe_pkg::queue_status_t             status_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [7:0]                         out_byte_o,
  output logic                               byte_valid_o,
  output logic                               run_last_o,
  output logic [upe_pkg::TOTAL_W-1:0]        total_count_o
);
  import upe_pkg::*;

  typedef enum logic [2:0] {
    PH_PCT = 3'b001,
    PH_HI  = 3'b010,
    PH_LO  = 3'b100
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_byte_q, out_byte_d;
  logic               byte_valid_q, byte_valid_d;
  logic               run_last_q, run_last_d;
  logic [TOTAL_W-1:0] count_q, count_d;
  logic               slot, load;
  logic [TOTAL_W-1:0] total_inc, total_esc;

  function automatic logic [TOTAL_W-1:0] sat_add(logic [TOTAL_W-1:0] a, logic inc);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, a} + (TOTAL_W + 1)'(inc);
    return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  endfunction

  assign slot      = !out_valid_q || !out_stall_i;
  assign total_inc = sat_add(total_q, 1'b1);
  assign total_esc = sat_add(total_q, head_i.esc);

  always_comb begin
    pop_o        = 1'b0;
    load         = 1'b0;
    phase_d      = phase_q;
    total_d      = total_q;
    out_byte_d   = out_byte_q;
    byte_valid_d = byte_valid_q;
    run_last_d   = run_last_q;
    count_d      = count_q;
    if (!status_i.empty) begin
      if (head_i.count_only) begin
        if (!head_i.last) begin
          pop_o   = 1'b1;
          total_d = total_esc;
        end else if (slot) begin
          load         = 1'b1;
          pop_o        = 1'b1;
          out_byte_d   = 8'h00;
          byte_valid_d = 1'b0;
          run_last_d   = 1'b1;
          count_d      = total_esc;
          total_d      = '0;
        end
      end else if (slot) begin
        load         = 1'b1;
        byte_valid_d = 1'b1;
        count_d      = total_inc;
        if (head_i.esc) begin
          unique case (phase_q)
            PH_PCT: begin
              out_byte_d = 8'h25;
              run_last_d = 1'b0;
              phase_d    = PH_HI;
            end
            PH_HI: begin
              out_byte_d = hex_digit(head_i.src_byte[7:4]);
              run_last_d = 1'b0;
              phase_d    = PH_LO;
            end
            PH_LO: begin
              out_byte_d = hex_digit(head_i.src_byte[3:0]);
              run_last_d = 1'b1;
              pop_o      = 1'b1;
              phase_d    = PH_PCT;
            end
            default: begin
              out_byte_d = 8'h25;
              run_last_d = 1'b0;
              phase_d    = PH_HI;
            end
          endcase
        end else begin
          out_byte_d = head_i.src_byte;
          run_last_d = 1'b1;
          pop_o      = 1'b1;
        end
        total_d = (pop_o && head_i.last) ? '0 : total_inc;
      end
    end
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PCT;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q   <= out_byte_d;
      byte_valid_q <= byte_valid_d;
      run_last_q   <= run_last_d;
      count_q      <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_valid_o  = byte_valid_q;
  assign run_last_o    = run_last_q;
  assign total_count_o = count_q;

endmodule

`default_nettype wire

[src/uri_percent_escape.sv]
// ----------------------------------------------------------------------------
// uri_percent_escape: percent-encoding of a byte stream
// Accepted bytes enter the command queue; the result register loads from
// the queue head when free: one slot per plain byte, three per escaped byte
// (one per emitted byte); count-mode bytes before the last need no slot.
// Reset: config, running total, queue and output valid clear at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "uri_percent_escape_defines.svh"

module uri_percent_escape #(
  parameter int unsigned QUEUE_DEPTH = upe_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [0:0]                     cfg_index_i,
  input  wire logic [upe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     src_byte_i,
  input  wire logic                           src_last_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [7:0]                          out_byte_o,
  output logic                                byte_valid_o,
  output logic                                run_last_o,
  output logic [upe_pkg::TOTAL_W-1:0]         total_count_o
);
  import upe_pkg::*;

  cmd_t          front_cmd, head_cmd;
  queue_status_t q_status;
  logic          push, pop;
  logic          out_fire, data_out, report_out, pct_open;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_status.full;
  assign push        = in_valid_i && !q_status.full;

  upe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .src_byte_i  (src_byte_i),
    .src_last_i  (src_last_i),
    .cmd_o       (front_cmd)
  );

  upe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .status_o    (q_status)
  );

  upe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_cmd),
    .status_i      (q_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .run_last_o    (run_last_o),
    .total_count_o (total_count_o)
  );

  assign out_fire   = out_valid_o && !out_stall_i;
  assign data_out   = out_valid_o && byte_valid_o;
  assign report_out = out_valid_o && !byte_valid_o;
  assign pct_open   = out_fire && byte_valid_o && (out_byte_o == 8'h25) && !run_last_o;

  `UPE_ASSERT(a_data_total_nonzero, !data_out || (total_count_o != '0), "data with zero total")
  `UPE_ASSERT(a_report_shape, !report_out || (run_last_o && (out_byte_o == '0)), "bad report")
  `UPE_ASSERT_NEXT(a_pct_followed, pct_open, data_out && !run_last_o, "broken escape after pct")
  `UPE_ASSERT(a_pop_needs_entry, !pop || !q_status.empty, "pop from empty queue")

endmodule

`default_nettype wire

[tb/sv/uri_percent_escape_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uri_percent_escape_tb
// Self-checking bench for the percent-escape block. A directed table covers
// every escape set, the out-of-range sets, count mode and a mid-string mode
// change. Random strings follow under three stall mixes. Each result is
// compared with an in-bench model of the encoder, or with the table's pinned values.
// ----------------------------------------------------------------------------
module uri_percent_escape_tb;
  import upe_pkg::*;

  localparam int          SETTLE_CYC  = 8;
  localparam int          LIMIT_CYC   = 2_000_000;
  localparam logic [2:0]  NO_SET_5    = 3'd5;
  localparam logic [2:0]  NO_SET_6    = 3'd6;
  localparam logic [2:0]  NO_SET_7    = 3'd7;

  // escape bitmaps, one 32-bit word per block of 32 byte codes
  localparam logic [31:0] ESC_WORDS [5][8] = '{
    '{32'hffffffff, 32'h80000029, 32'h00000000, 32'h80000000,
      32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
    '{32'hffffffff, 32'h88000869, 32'h00000000, 32'h80000000,
      32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
    '{32'hffffffff, 32'hfc009fff, 32'h78000001, 32'hb8000001,
      32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
    '{32'hffffffff, 32'h000000ad, 32'h00000000, 32'h80000000,
      32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
    '{32'hffffffff, 32'h00000021, 32'h00000000, 32'h00000000,
      32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000}
  };

  localparam logic [7:0] HEX_CHARS [16] = '{
    "0", "1", "2", "3", "4", "5", "6", "7",
    "8", "9", "a", "b", "c", "d", "e", "f"
  };

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               run_last;
    logic [TOTAL_W-1:0] total_count;
  } enc_res_t;

  typedef enum logic {
    ROW_CFG,
    ROW_SRC
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    cfg_idx_e           reg_idx;
    logic [2:0]         reg_val;
    logic [7:0]         src;
    logic               last;
    logic               pinned;
    logic [7:0]         pin_byte;
    logic               pin_bv;
    logic [TOTAL_W-1:0] pin_total;
  } dir_row_t;

  localparam int DIR_N = 35;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h61, 1'b0, 1'b1, 8'h61, 1'b1, 18'd1},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h00, 1'b0, 1'b1, 8'h30, 1'b1, 18'd4},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'hff, 1'b1, 1'b1, 8'h66, 1'b1, 18'd7},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h7f, 1'b1, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h20, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_CFG, CFG_ESCAPE_SET, SET_ARGS,      8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h26, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h2b, 1'b1, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_CFG, CFG_ESCAPE_SET, SET_COMPONENT, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h7e, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h2f, 1'b1, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_CFG, CFG_ESCAPE_SET, SET_URL,       8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h22, 1'b1, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_CFG, CFG_ESCAPE_SET, SET_MAIL,      8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h80, 1'b1, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h25, 1'b1, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_CFG, CFG_ESCAPE_SET, NO_SET_7,      8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 18'd1},
    '{ROW_CFG, CFG_ESCAPE_SET, NO_SET_5,      8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h20, 1'b1, 1'b1, 8'h20, 1'b1, 18'd1},
    '{ROW_CFG, CFG_ESCAPE_SET, SET_URI,       8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_CFG, CFG_COUNT_ONLY, 3'd1,          8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h41, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'hff, 1'b1, 1'b1, 8'h00, 1'b0, 18'd2},
    '{ROW_CFG, CFG_ESCAPE_SET, NO_SET_6,      8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 18'd0},
    '{ROW_CFG, CFG_COUNT_ONLY, 3'd6,          8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_CFG, CFG_ESCAPE_SET, SET_COMPONENT, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h5a, 1'b1, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_CFG, CFG_ESCAPE_SET, SET_URI,       8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h61, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_CFG, CFG_COUNT_ONLY, 3'd3,          8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h20, 1'b0, 1'b0, 8'h00, 1'b0, 18'd0},
    '{ROW_SRC, CFG_ESCAPE_SET, 3'd0,          8'h62, 1'b1, 1'b1, 8'h00, 1'b0, 18'd2}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [0:0]         cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         src_byte_i;
  logic               src_last_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [7:0]         out_byte_o;
  logic               byte_valid_o;
  logic               run_last_o;
  logic [TOTAL_W-1:0] total_count_o;

  logic [TOTAL_W-1:0] run_total;
  logic [2:0]         cur_set;
  logic               cur_count;
  enc_res_t           enc_q[$];
  int                 fail_cnt = 0;
  int                 cyc_cnt = 0;
  int                 snd_idle_pct = 0;
  int                 rcv_idle_pct = 0;

  uri_percent_escape i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .src_byte_i    (src_byte_i),
    .src_last_i    (src_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .run_last_o    (run_last_o),
    .total_count_o (total_count_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= LIMIT_CYC) begin
      $display("uri_percent_escape verification failed");
      $finish;
    end
  end

  // ---- encoder model ----
  function automatic logic esc_hit(logic [2:0] sel, logic [7:0] b);
    if (sel > SET_MAIL) return 1'b0;
    return ESC_WORDS[sel][b[7:5]][b[4:0]];
  endfunction

  function automatic void bump_total();
    if (run_total != TOTAL_MAX) run_total = run_total + 1'b1;
  endfunction

  function automatic void push_res(logic [7:0] ob, logic bv, logic rl);
    enc_q.push_back('{ob, bv, rl, run_total});
  endfunction

  function automatic void encode_src(logic [7:0] b, logic last);
    logic hit;
    hit = esc_hit(cur_set, b);
    if (cur_count) begin
      if (hit) bump_total();
      if (last) push_res(8'h00, 1'b0, 1'b1);
    end else if (hit) begin
      bump_total();
      push_res("%", 1'b1, 1'b0);
      bump_total();
      push_res(HEX_CHARS[b[7:4]], 1'b1, 1'b0);
      bump_total();
      push_res(HEX_CHARS[b[3:0]], 1'b1, 1'b1);
    end else begin
      bump_total();
      push_res(b, 1'b1, 1'b1);
    end
    if (last) run_total = '0;
  endfunction

  // ---- result checker ----
  function automatic void report_mismatch(string field, int unsigned want, int unsigned got);
    $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    fail_cnt++;
  endfunction

  always @(posedge clk_i) begin
    enc_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (enc_q.size() == 0) begin
        $error("result with no request pending: out_byte 0x%0h", out_byte_o);
        fail_cnt++;
      end else begin
        want = enc_q.pop_front();
        if (out_byte_o !== want.out_byte)
          report_mismatch("out_byte", want.out_byte, out_byte_o);
        if (byte_valid_o !== want.byte_valid)
          report_mismatch("byte_valid", want.byte_valid, byte_valid_o);
        if (run_last_o !== want.run_last)
          report_mismatch("run_last", want.run_last, run_last_o);
        if (total_count_o !== want.total_count)
          report_mismatch("total_count", want.total_count, total_count_o);
      end
    end
  end

  // ---- drivers, all called at a falling edge ----
  task automatic send_src(input logic [7:0] b, input logic last);
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    src_byte_i <= b;
    src_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    encode_src(b, last);
    @(negedge clk_i);
  endtask

  // lets every pending result drain, plus slack for requests with no result
  task automatic wait_idle();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (enc_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [2:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_ESCAPE_SET) cur_set = val;
    else cur_count = val[0];
    @(negedge clk_i);
  endtask

  task automatic run_strings(input int snd_pct, input int rcv_pct, input int n_items);
    int         sent;
    int         len;
    logic [7:0] b;
    logic [1:0] pad;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      if ($urandom_range(9) < 8) write_reg(CFG_ESCAPE_SET, 3'($urandom_range(4)));
      else write_reg(CFG_ESCAPE_SET, 3'($urandom_range(7)));
      pad = 2'($urandom_range(3));
      write_reg(CFG_COUNT_ONLY, {pad, ($urandom_range(3) == 0)});
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(1) == 0) b = 8'($urandom_range(255));
        else b = 8'($urandom_range(8'h7e, 8'h20));
        // occasional mode flip inside a string
        if (i != 0 && $urandom_range(11) == 0) begin
          wait_idle();
          pad = 2'($urandom_range(3));
          write_reg(CFG_COUNT_ONLY, {pad, ~cur_count});
        end
        send_src(b, i == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ESCAPE_SET;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    src_byte_i  = '0;
    src_last_i  = 1'b0;
    run_total   = '0;
    cur_set     = SET_URI;
    cur_count   = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    snd_idle_pct = 27;
    rcv_idle_pct = 54;
    for (int r = 0; r < DIR_N; r++) begin
      if (DIR_ROWS[r].kind == ROW_CFG) begin
        wait_idle();
        write_reg(DIR_ROWS[r].reg_idx, DIR_ROWS[r].reg_val);
      end else begin
        send_src(DIR_ROWS[r].src, DIR_ROWS[r].last);
        if (DIR_ROWS[r].pinned) begin
          enc_q[enc_q.size()-1].out_byte    = DIR_ROWS[r].pin_byte;
          enc_q[enc_q.size()-1].byte_valid  = DIR_ROWS[r].pin_bv;
          enc_q[enc_q.size()-1].total_count = DIR_ROWS[r].pin_total;
        end
      end
    end

    run_strings(27, 54, 30);
    run_strings(54, 27, 30);
    run_strings(0, 0, 30);

    wait_idle();
    if (fail_cnt == 0 && enc_q.size() == 0) begin
      $display("uri_percent_escape verification clean");
    end else begin
      $display("uri_percent_escape verification failed");
    end
    $finish;
  end

endmodule
